### design/sm4_pkg.sv
// ----------------------------------------------------------------------------
// sm4_pkg
// types, constants and round functions shared by the sm4 block cipher
// ----------------------------------------------------------------------------
package sm4_pkg;

    localparam int ROUNDS = 32;

    typedef struct packed {
        logic        mode;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } sm4_req_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } sm4_res_t;

    typedef enum logic [1:0] {
        KEY_IDLE,
        KEY_LOAD,
        KEY_RUN
    } key_state_t;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic [31:0] FK [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] v);
        tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] lin_data(input logic [31:0] b);
        lin_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] lin_key(input logic [31:0] b);
        lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // byte j of ck[i] is (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [4:0] i);
        logic [7:0] base;
        base = {1'b0, i, 2'b00};
        ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
                   8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
    endfunction

endpackage

### design/sm4_block_cipher_top.sv
// ----------------------------------------------------------------------------
// sm4_block_cipher_top
// sm4 128-bit block cipher, one round per pipeline stage
// ----------------------------------------------------------------------------
// a request is taken at a rising edge with start high and busy low; it carries
// a mode bit (0 encrypt, 1 decrypt) and the 128-bit block. the result shows on
// result for exactly one cycle with done high, once the block has passed
// all 32 round stages. a new request can be taken every cycle while busy is
// low; the stages, one sm4 round each, hold up to 32 blocks in flight.
// the key is written through cfg_we / cfg_index / cfg_data (index 0 key_high,
// index 1 key_low); the user must do so only while no block is in flight, as
// the block does not enforce it. after each write, and after reset (all-zero
// key), a key schedule sequencer derives round keys, one a cycle, with busy high.
// the receiver cannot hold off results, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module sm4_block_cipher_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sm4_pkg::sm4_req_t request,
    output logic              done,
    output sm4_pkg::sm4_res_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data
);
    import sm4_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    key_state_t  kstate_reg, kstate_next;
    logic [4:0]  kcnt_reg, kcnt_next;
    logic [31:0] kw_reg [4];
    logic [31:0] rk_reg [ROUNDS];
    logic [31:0] nk;

    logic        valid_reg [ROUNDS];
    logic        mode_reg  [ROUNDS];
    logic [31:0] x_reg     [ROUNDS][4];

    assign busy = (kstate_reg != KEY_IDLE);

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign nk = kw_reg[0] ^ lin_key(tau(kw_reg[1] ^ kw_reg[2] ^ kw_reg[3] ^ ck_word(kcnt_reg)));

    always_comb
    begin
        kstate_next = kstate_reg;
        kcnt_next   = kcnt_reg;
        case (kstate_reg)
            KEY_IDLE:
            begin
                if (cfg_we)
                    kstate_next = KEY_LOAD;
            end
            KEY_LOAD:
            begin
                kcnt_next = '0;
                if (!cfg_we)
                    kstate_next = KEY_RUN;
            end
            KEY_RUN:
            begin
                kcnt_next = kcnt_reg + 5'd1;
                if (cfg_we)
                    kstate_next = KEY_LOAD;
                else if (kcnt_reg == 5'(ROUNDS - 1))
                    kstate_next = KEY_IDLE;
            end
            default: kstate_next = KEY_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kstate_reg <= KEY_LOAD;
            kcnt_reg   <= '0;
        end
        else
        begin
            kstate_reg <= kstate_next;
            kcnt_reg   <= kcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kstate_reg == KEY_LOAD)
        begin
            kw_reg[0] <= key_high_reg[63:32] ^ FK[0];
            kw_reg[1] <= key_high_reg[31:0]  ^ FK[1];
            kw_reg[2] <= key_low_reg[63:32]  ^ FK[2];
            kw_reg[3] <= key_low_reg[31:0]   ^ FK[3];
        end
        else if (kstate_reg == KEY_RUN)
        begin
            kw_reg[0] <= kw_reg[1];
            kw_reg[1] <= kw_reg[2];
            kw_reg[2] <= kw_reg[3];
            kw_reg[3] <= nk;
            rk_reg[kcnt_reg] <= nk;
        end
    end

    // round pipeline
    for (genvar s = 0; s < ROUNDS; s++)
    begin : g_round
        logic        v_in;
        logic        m_in;
        logic [31:0] x_in [4];
        logic [31:0] rk;
        logic [31:0] nx;

        if (s == 0)
        begin : g_first
            assign v_in    = start && !busy;
            assign m_in    = request.mode;
            assign x_in[0] = request.block_high[63:32];
            assign x_in[1] = request.block_high[31:0];
            assign x_in[2] = request.block_low[63:32];
            assign x_in[3] = request.block_low[31:0];
        end
        else
        begin : g_next
            assign v_in = valid_reg[s-1];
            assign m_in = mode_reg[s-1];
            assign x_in = x_reg[s-1];
        end

        assign rk = m_in ? rk_reg[ROUNDS-1-s] : rk_reg[s];
        assign nx = x_in[0] ^ lin_data(tau(x_in[1] ^ x_in[2] ^ x_in[3] ^ rk));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            mode_reg[s]  <= m_in;
            x_reg[s][0]  <= x_in[1];
            x_reg[s][1]  <= x_in[2];
            x_reg[s][2]  <= x_in[3];
            x_reg[s][3]  <= nx;
        end
    end

    assign done               = valid_reg[ROUNDS-1];
    assign result.result_high = {x_reg[ROUNDS-1][3], x_reg[ROUNDS-1][2]};
    assign result.result_low  = {x_reg[ROUNDS-1][1], x_reg[ROUNDS-1][0]};

endmodule
